[rtl/core/abt_pkg.sv]
// abt_pkg: request and status codes, and the command/status bundles that pass
// between the array BST controller and its datapath.
// No dependencies.
package abt_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_FIND   = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_HEIGHT = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_ZERO   = 2'd3;

  // which child slot the datapath forms: left/right of x, left/right of y
  typedef enum logic [1:0] {
    C_XL = 2'd0,
    C_XR = 2'd1,
    C_YL = 2'd2,
    C_YR = 2'd3
  } child_sel_t;

  typedef struct packed {
    logic       cnt_inc;
    logic       wr_zero_cnt;
    logic       load_req;
    logic       idx_rd;
    logic       idx_step;
    logic       set_status;
    logic [1:0] status_val;
    logic       set_slot_idx;
    logic       wr_key_idx;
    logic       x_from_idx;
    child_sel_t c_sel;
    logic       c_rd;
    logic       y_from_c;
    logic       wr_x_yv;
    logic       wr_y_key;
    logic       x_from_y;
    logic       wr_x_zero;
    logic       scan_rd;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       key_zero;
    logic       idx_oob;
    logic       c_oob;
    logic       rd_zero;
    logic       rd_eq;
    logic       cnt_last;
  } sts_t;

endpackage

[rtl/core/abt_datapath.sv]
// abt_datapath: slot memory, descent and swap index registers, height scan
// and the result register. Driven by abt_ctrl; uses abt_pkg.
module abt_datapath import abt_pkg::*; #(
  parameter int SLOTS = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] key,
  output logic [1:0]         status,
  output logic [5:0]         slot,
  output logic [2:0]         levels
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 2;
  localparam int LW = $clog2(CW + 1);
  localparam int SW = IW + 6;

  logic signed [31:0] mem [SLOTS];
  logic signed [31:0] rdata;

  logic [1:0]         op;
  logic signed [31:0] key_r;
  logic [CW-1:0]      idx;
  logic [IW-1:0]      x;
  logic [IW-1:0]      y;
  logic signed [31:0] yv;
  logic [IW-1:0]      cnt;
  logic [1:0]         status_r;
  logic [IW-1:0]      slot_r;
  logic [2:0]         best;
  logic               pend_valid;
  logic [2:0]         pend_lvl;

  logic [CW-1:0]      c;
  logic [CW-1:0]      idx_child;
  logic [IW-1:0]      rd_addr;
  logic               rd_en;
  logic [IW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic               wr_en;
  logic [CW-1:0]      cnt1;
  logic [LW-1:0]      lvl;
  logic [2:0]         lvl_sat;
  logic [SW-1:0]      slot_wide;

  always_comb begin
    case (cmd.c_sel)
      C_XL:    c = (CW'(x) << 1) + CW'(1);
      C_XR:    c = (CW'(x) << 1) + CW'(2);
      C_YL:    c = (CW'(y) << 1) + CW'(1);
      C_YR:    c = (CW'(y) << 1) + CW'(2);
      default: c = '0;
    endcase
  end

  // ties go left
  assign idx_child = (idx << 1) + ((rdata >= key_r) ? CW'(1) : CW'(2));

  always_comb begin
    rd_en   = cmd.idx_rd | cmd.c_rd | cmd.scan_rd;
    rd_addr = idx[IW-1:0];
    if (cmd.scan_rd) rd_addr = cnt;
    else if (cmd.c_rd) rd_addr = c[IW-1:0];
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = x;
    wr_data = '0;
    if (cmd.wr_zero_cnt) begin
      wr_addr = cnt;
    end else if (cmd.wr_key_idx) begin
      wr_addr = idx[IW-1:0];
      wr_data = key_r;
    end else if (cmd.wr_x_yv) begin
      wr_data = yv;
    end else if (cmd.wr_y_key) begin
      wr_addr = y;
      wr_data = key_r;
    end else if (!cmd.wr_x_zero) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // level of a slot = bit length of (index + 1)
  always_comb begin
    cnt1 = CW'(cnt) + CW'(1);
    lvl  = '0;
    for (int b = 0; b < CW; b++) begin
      if (cnt1[b]) lvl = LW'(b + 1);
    end
    lvl_sat = (lvl > LW'(7)) ? 3'd7 : lvl[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= cmd.scan_rd;
      if (cmd.load_req) cnt <= '0;
      else if (cmd.cnt_inc) cnt <= cnt + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    pend_lvl <= lvl_sat;
    if (cmd.load_req) begin
      op       <= req_type;
      key_r    <= key;
      idx      <= '0;
      status_r <= ST_OK;
      slot_r   <= '0;
      best     <= '0;
    end else begin
      // scan in ascending order, so the last occupied slot is the deepest
      if (pend_valid && rdata != 0) best <= pend_lvl;
      if (cmd.set_status) status_r <= cmd.status_val;
      if (cmd.set_slot_idx) slot_r <= idx[IW-1:0];
      if (cmd.idx_step) idx <= idx_child;
    end
    if (cmd.x_from_idx) x <= idx[IW-1:0];
    else if (cmd.x_from_y) x <= y;
    if (cmd.y_from_c) begin
      y  <= c[IW-1:0];
      yv <= rdata;
    end
  end

  assign slot_wide = SW'(slot_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= status_r;
      slot   <= slot_wide[5:0];
      levels <= best;
    end
  end

  assign sts.op       = op;
  assign sts.key_zero = (key_r == 0);
  assign sts.idx_oob  = (idx >= CW'(SLOTS));
  assign sts.c_oob    = (c >= CW'(SLOTS));
  assign sts.rd_zero  = (rdata == 0);
  assign sts.rd_eq    = (rdata == key_r);
  assign sts.cnt_last = (cnt == IW'(SLOTS - 1));

endmodule

[rtl/core/abt_ctrl.sv]
// abt_ctrl: sequencer for clear pass, descent, delete swaps and height scan.
// Commands abt_datapath; uses abt_pkg.
module abt_ctrl import abt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [16:0] {
    S_CLEAR    = 17'h00001,
    S_IDLE     = 17'h00002,
    S_START    = 17'h00004,
    S_WALK_RD  = 17'h00008,
    S_WALK_EV  = 17'h00010,
    S_DEL_L    = 17'h00020,
    S_DEL_LEV  = 17'h00040,
    S_DEL_R    = 17'h00080,
    S_DEL_REV  = 17'h00100,
    S_DESC_R   = 17'h00200,
    S_DESC_REV = 17'h00400,
    S_DESC_L   = 17'h00800,
    S_DESC_LEV = 17'h01000,
    S_SWAP_X   = 17'h02000,
    S_SWAP_Y   = 17'h04000,
    S_SCAN     = 17'h08000,
    S_DONE     = 17'h10000
  } state_t;

  state_t state, state_next;
  logic   scan_end, scan_end_next;
  logic   out_valid_next;

  always_comb begin
    cmd            = '0;
    cmd.c_sel      = C_XL;
    state_next     = state;
    scan_end_next  = 1'b0;
    in_ready       = 1'b0;
    out_valid_next = out_valid & ~out_ready;
    case (state)
      S_CLEAR: begin
        cmd.wr_zero_cnt = 1'b1;
        cmd.cnt_inc     = 1'b1;
        if (sts.cnt_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_START;
        end
      end
      S_START: begin
        if (sts.op == REQ_HEIGHT) begin
          state_next = S_SCAN;
        end else if (sts.key_zero) begin
          cmd.set_status = 1'b1;
          cmd.status_val = ST_ZERO;
          state_next     = S_SCAN;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (sts.idx_oob) begin
          cmd.set_status = 1'b1;
          cmd.status_val = (sts.op == REQ_INSERT) ? ST_FULL : ST_ABSENT;
          state_next     = S_SCAN;
        end else begin
          cmd.idx_rd = 1'b1;
          state_next = S_WALK_EV;
        end
      end
      S_WALK_EV: begin
        if (sts.rd_zero) begin
          if (sts.op == REQ_INSERT) begin
            cmd.wr_key_idx   = 1'b1;
            cmd.set_slot_idx = 1'b1;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status_val = ST_ABSENT;
          end
          state_next = S_SCAN;
        end else if (sts.op != REQ_INSERT && sts.rd_eq) begin
          if (sts.op == REQ_FIND) begin
            cmd.set_slot_idx = 1'b1;
            state_next       = S_SCAN;
          end else begin
            cmd.x_from_idx = 1'b1;
            state_next     = S_DEL_L;
          end
        end else begin
          cmd.idx_step = 1'b1;
          state_next   = S_WALK_RD;
        end
      end
      S_DEL_L: begin
        cmd.c_sel = C_XL;
        if (sts.c_oob) begin
          state_next = S_DEL_R;
        end else begin
          cmd.c_rd   = 1'b1;
          state_next = S_DEL_LEV;
        end
      end
      S_DEL_LEV: begin
        cmd.c_sel = C_XL;
        if (!sts.rd_zero) begin
          cmd.y_from_c = 1'b1;
          state_next   = S_DESC_R;
        end else begin
          state_next = S_DEL_R;
        end
      end
      S_DEL_R: begin
        cmd.c_sel = C_XR;
        if (sts.c_oob) begin
          cmd.wr_x_zero = 1'b1;
          state_next    = S_SCAN;
        end else begin
          cmd.c_rd   = 1'b1;
          state_next = S_DEL_REV;
        end
      end
      S_DEL_REV: begin
        cmd.c_sel = C_XR;
        if (!sts.rd_zero) begin
          cmd.y_from_c = 1'b1;
          state_next   = S_DESC_L;
        end else begin
          cmd.wr_x_zero = 1'b1;
          state_next    = S_SCAN;
        end
      end
      // rightmost node of the left subtree
      S_DESC_R: begin
        cmd.c_sel = C_YR;
        if (sts.c_oob) begin
          state_next = S_SWAP_X;
        end else begin
          cmd.c_rd   = 1'b1;
          state_next = S_DESC_REV;
        end
      end
      S_DESC_REV: begin
        cmd.c_sel = C_YR;
        if (!sts.rd_zero) begin
          cmd.y_from_c = 1'b1;
          state_next   = S_DESC_R;
        end else begin
          state_next = S_SWAP_X;
        end
      end
      // leftmost node of the right subtree
      S_DESC_L: begin
        cmd.c_sel = C_YL;
        if (sts.c_oob) begin
          state_next = S_SWAP_X;
        end else begin
          cmd.c_rd   = 1'b1;
          state_next = S_DESC_LEV;
        end
      end
      S_DESC_LEV: begin
        cmd.c_sel = C_YL;
        if (!sts.rd_zero) begin
          cmd.y_from_c = 1'b1;
          state_next   = S_DESC_L;
        end else begin
          state_next = S_SWAP_X;
        end
      end
      S_SWAP_X: begin
        cmd.wr_x_yv = 1'b1;
        state_next  = S_SWAP_Y;
      end
      S_SWAP_Y: begin
        // value at x is always the key being deleted
        cmd.wr_y_key = 1'b1;
        cmd.x_from_y = 1'b1;
        state_next   = S_DEL_L;
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
          cmd.cnt_inc = 1'b1;
          scan_end_next = sts.cnt_last;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scan_end  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      scan_end  <= scan_end_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/core/array_bst_table_top.sv]
// array_bst_table_top: implicit binary search tree in a slot array.
// Instantiates abt_ctrl and abt_datapath; uses abt_pkg.
//
// Input channel (in_valid/in_ready) carries req_type and key; output channel
// (out_valid/out_ready) carries status, slot and levels, one result beat per
// request beat, in order.
// After reset the slot memory is cleared one slot a cycle, with in_ready
// low. Then one request is worked on at a time, in these steps:
//   taking and decoding the beat (IDLE, START),
//   the ordered descent, one memory read per level (WALK_RD, WALK_EV),
//   delete: child probes and swaps (DEL_*, DESC_*, SWAP_X, SWAP_Y),
//   the height scan over every slot (SCAN),
//   loading the result register (DONE).
// The full height scan takes most of the time for a shallow tree. A
// result waiting in the output register does not stop the next beat from
// being taken; only when a second result is ready while out_ready stays low
// does the block hold in DONE.
module array_bst_table_top import abt_pkg::*; #(
  parameter int SLOTS = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [5:0]         slot,
  output logic [2:0]         levels
);

  cmd_t cmd;
  sts_t sts;

  abt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  abt_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req_type (req_type),
    .key      (key),
    .status   (status),
    .slot     (slot),
    .levels   (levels)
  );

endmodule

[dv/abt_result_checker.sv]
// abt_result_checker: watches both channels of array_bst_table_top, keeps a shadow slot
// array of the tree, works out each answer and compares it with the result beats.
// Depends on abt_pkg for the request and status codes.
module abt_result_checker import abt_pkg::*; #(
  parameter int SLOTS = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] key,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic [5:0]         slot,
  input  logic [2:0]         levels,
  output int                 mismatches,
  output int                 outstanding,
  output int                 requests_seen,
  output int                 full_refusals,
  output int                 deletes_done,
  output int                 tallest
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] k;
    logic [1:0]         st;
    logic [5:0]         sl;
    logic [2:0]         lv;
  } answer_t;

  logic signed [31:0] tree_slot [SLOTS];
  answer_t            due_answers [$];

  // slots past the array count as empty
  function automatic bit filled(int i);
    return i < SLOTS && tree_slot[i] != 0;
  endfunction

  // ordered descent, first match wins; SLOTS when absent
  function automatic int seek(logic signed [31:0] k);
    int i = 0;
    while (filled(i)) begin
      if (tree_slot[i] == k) return i;
      i = (tree_slot[i] >= k) ? 2 * i + 1 : 2 * i + 2;
    end
    return SLOTS;
  endfunction

  // only slots joined to the root by occupied slots count towards height
  function automatic logic [2:0] height_now();
    bit on_path [SLOTS];
    int deepest = 0;
    for (int i = 0; i < SLOTS; i++) begin
      on_path[i] = ((i == 0) || on_path[(i - 1) / 2]) && tree_slot[i] != 0;
      if (on_path[i] && $clog2(i + 2) > deepest) deepest = $clog2(i + 2);
    end
    return (deepest > 7) ? 3'd7 : 3'(deepest);
  endfunction

  task automatic work_request(input logic [1:0] op, input logic signed [31:0] k,
                              output answer_t a);
    int                 x;
    int                 y;
    logic signed [31:0] t;
    bit                 settled;
    a.op = op;
    a.k  = k;
    a.st = ST_OK;
    a.sl = '0;
    if (op != REQ_HEIGHT && k == 0) begin
      a.st = ST_ZERO;
    end else begin
      case (op)
        REQ_INSERT: begin
          x = 0;
          while (x < SLOTS && tree_slot[x] != 0)
            x = (tree_slot[x] >= k) ? 2 * x + 1 : 2 * x + 2;
          if (x >= SLOTS) begin
            a.st = ST_FULL;
            full_refusals++;
          end else begin
            tree_slot[x] = k;
            a.sl = 6'(x);
          end
        end
        REQ_FIND: begin
          x = seek(k);
          if (x >= SLOTS) a.st = ST_ABSENT;
          else a.sl = 6'(x);
        end
        REQ_DELETE: begin
          x = seek(k);
          if (x >= SLOTS) begin
            a.st = ST_ABSENT;
          end else begin
            // push the value down by swaps until it is a leaf, then clear it
            settled = 1'b0;
            while (!settled) begin
              if (filled(2 * x + 1)) begin
                y = 2 * x + 1;
                while (filled(2 * y + 2)) y = 2 * y + 2;
              end else if (filled(2 * x + 2)) begin
                y = 2 * x + 2;
                while (filled(2 * y + 1)) y = 2 * y + 1;
              end else begin
                tree_slot[x] = '0;
                settled = 1'b1;
              end
              if (!settled) begin
                t            = tree_slot[x];
                tree_slot[x] = tree_slot[y];
                tree_slot[y] = t;
                x            = y;
              end
            end
            deletes_done++;
          end
        end
        default: ;
      endcase
    end
    a.lv = height_now();
    if (a.lv > tallest) tallest = a.lv;
  endtask

  always @(posedge clk) begin : watch
    answer_t want;
    if (rst) begin
      foreach (tree_slot[i]) tree_slot[i] = '0;
      due_answers.delete();
    end else begin
      if (in_valid && in_ready) begin
        work_request(req_type, key, want);
        due_answers.push_back(want);
        requests_seen++;
      end
      if (out_valid && out_ready) begin
        if (due_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result beat with no request outstanding: status %0d slot %0d levels %0d",
                     $time, status, slot, levels);
        end else begin
          want = due_answers.pop_front();
          if (status !== want.st || slot !== want.sl || levels !== want.lv) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] op %0d key %0d: want status %0d slot %0d levels %0d, got %0d %0d %0d",
                       $time, want.op, want.k, want.st, want.sl, want.lv, status, slot, levels);
          end
        end
      end
    end
    outstanding = due_answers.size();
  end

endmodule

[dv/tb_array_bst_table_top.sv]
// tb_array_bst_table_top: drives requests into array_bst_table_top with bursty valid and
// a stalling receiver; abt_result_checker does the checking. Depends on abt_pkg,
// abt_result_checker and the block's RTL.
module tb_array_bst_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import abt_pkg::*;

  localparam int SLOTS       = 63;
  localparam int REQUESTS    = 1800;
  localparam int STALL_LIMIT = 3000;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [1:0]         req_type  = REQ_HEIGHT;
  logic signed [31:0] key       = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [5:0]         slot;
  logic [2:0]         levels;

  int mismatches;
  int outstanding;
  int requests_seen;
  int full_refusals;
  int deletes_done;
  int tallest;

  int                 n_sent      = 0;
  int                 burst_left  = 0;
  int                 quiet_cycles = 0;
  logic signed [31:0] live_keys [$];

  array_bst_table_top #(.SLOTS(SLOTS)) i_dut (
    .clk, .rst, .in_valid, .in_ready, .req_type, .key,
    .out_valid, .out_ready, .status, .slot, .levels
  );

  abt_result_checker #(.SLOTS(SLOTS)) i_checker (
    .clk, .rst, .in_valid, .in_ready, .req_type, .key,
    .out_valid, .out_ready, .status, .slot, .levels,
    .mismatches, .outstanding, .requests_seen, .full_refusals, .deletes_done, .tallest
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one beat; keys inserted are remembered so later finds and deletes hit them
  task automatic send_item(input logic [1:0] op, input logic signed [31:0] k);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= op;
    key      <= k;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if (op == REQ_INSERT && k != 0 && live_keys.size() < 100) live_keys.push_back(k);
    if (op == REQ_DELETE) begin
      foreach (live_keys[i]) begin
        if (live_keys[i] == k) begin
          live_keys.delete(i);
          break;
        end
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 20);
      repeat (gap) @(negedge clk) in_valid <= 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] draw_key(int style);
    logic signed [31:0] v;
    case (style)
      0: v = $urandom_range(1, 15);
      1: v = $urandom_range(1, 1000);
      2: v = $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7fff_ffff;
          2:       v = 32'sh8000_0001;
          3:       v = 32'sh7fff_fffe;
          4:       v = 32'sd1 << $urandom_range(0, 31);
          default: v = ~(32'sd1 << $urandom_range(0, 30));
        endcase
      end
    endcase
    if (style < 2 && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // build a tree from one key style, mixing in finds, deletes and height queries,
  // and now and then tear it down again
  task automatic run_episode();
    int                 style;
    int                 count;
    int                 r;
    logic [1:0]         op;
    logic signed [31:0] k;
    style = $urandom_range(0, 3);
    count = $urandom_range(10, 60);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      op = REQ_INSERT;
      else if (r < 65) op = REQ_FIND;
      else if (r < 90) op = REQ_DELETE;
      else             op = REQ_HEIGHT;
      k = draw_key(style);
      if ((op == REQ_FIND || op == REQ_DELETE) && live_keys.size() > 0 &&
          $urandom_range(0, 9) < 7)
        k = live_keys[$urandom_range(0, live_keys.size() - 1)];
      if (op != REQ_HEIGHT && $urandom_range(0, 49) == 0) k = '0;
      if (op == REQ_HEIGHT) k = $urandom;
      send_item(op, k);
    end
    if ($urandom_range(0, 2) == 0) begin
      while (live_keys.size() > 0)
        send_item(REQ_DELETE, live_keys[$urandom_range(0, live_keys.size() - 1)]);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send_item(REQ_HEIGHT, '0);
    send_item(REQ_INSERT, '0);
    send_item(REQ_FIND, '0);
    send_item(REQ_DELETE, '0);
    send_item(REQ_FIND, 32'sd5);
    send_item(REQ_DELETE, 32'sd5);
    send_item(REQ_INSERT, 32'sd100);
    send_item(REQ_INSERT, 32'sh8000_0000);
    send_item(REQ_INSERT, 32'sh7fff_ffff);
    send_item(REQ_INSERT, 32'sd100);      // duplicate goes left
    send_item(REQ_INSERT, -32'sd1);
    send_item(REQ_FIND, 32'sd100);
    send_item(REQ_FIND, 32'sh7fff_ffff);
    send_item(REQ_FIND, 32'sd7);
    send_item(REQ_DELETE, 32'sd100);      // root with a left subtree
    send_item(REQ_HEIGHT, 32'shA5A5_A5A5);
    send_item(REQ_DELETE, 32'sh8000_0000);
    for (int i = 1; i <= 7; i++) send_item(REQ_INSERT, 32'sd1000 * i);  // ascending keys down one path to full

    hold_until_drained();

    while (n_sent < REQUESTS) begin
      run_episode();
      if ($urandom_range(0, 3) == 0) hold_until_drained();
    end

    @(negedge clk) in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (2 * (SLOTS + 40)) @(posedge clk);

    $display("%0d requests checked; %0d inserts refused as full, %0d deletes completed",
             requests_seen, full_refusals, deletes_done);
    $display("tallest tree reached %0d levels; %0d mismatches", tallest, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver: phases of always-ready, random stalls and long holds
  int rx_mode       = 0;
  int rx_phase_left = 0;
  int rx_hold       = 0;

  always @(negedge clk) begin : receiver
    bit rdy;
    if (rx_phase_left == 0) begin
      rx_mode       = $urandom_range(0, 2);
      rx_phase_left = $urandom_range(100, 600);
    end else begin
      rx_phase_left--;
    end
    case (rx_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 2) != 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(5, 40);
        end
      end
    endcase
    out_ready <= rdy;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat on either channel for %0d cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
